// File: rtl/pli_pkg.sv
// Package for the piecewise linear interpolator: widths, op and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;
    localparam int MAX_POINTS  = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int FRAC_W      = 16;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_LOW   = 3'd1;
    localparam logic [STAT_W-1:0] ST_HIGH  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EQUAL = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd5;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;
endpackage
`default_nettype wire

// File: rtl/pli_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  addr,
    input  wire [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/pli_div.sv
// Restoring divider for the interpolation weight, one quotient bit per cycle.
// Depends on pli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pli_div
    import pli_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  wire [VALUE_WIDTH:0]    num,   // magnitude, num < den
    input  wire [VALUE_WIDTH:0]    den,
    output logic                   busy,
    output logic [FRAC_W-1:0]      quo
);
    logic [VALUE_WIDTH+1:0] rem_reg;
    logic [VALUE_WIDTH:0]   den_reg;
    logic [FRAC_W-1:0]      q_reg;
    logic [4:0]             cnt_reg;
    logic [VALUE_WIDTH+1:0] sh;
    logic                   ge;

    assign sh   = {rem_reg[VALUE_WIDTH:0], 1'b0};
    assign ge   = sh >= {1'b0, den_reg};
    assign busy = cnt_reg != 5'd0;
    assign quo  = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 5'd0;
        end else if (start) begin
            cnt_reg <= 5'(FRAC_W);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 5'd1;
        end
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy) begin
            rem_reg <= ge ? sh - {1'b0, den_reg} : sh;
            q_reg   <= {q_reg[FRAC_W-2:0], ge};
        end
    end
endmodule
`default_nettype wire

// File: rtl/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise linear interpolator: sequencer around the point RAMs.
// Depends on pli_pkg, pli_ram and pli_div.
`timescale 1ns / 1ps
`default_nettype none
// Points live in two single-port RAMs (x and y). After the input beat, a clear
// goes straight to S_OUT and an append passes S_RD0, which writes the point
// unless the table is full. A query reads x[0], x[last], then walks up the
// table one point per S_WALK/S_WCHK pair (the x RAM read is registered), reads
// the two ordinates, runs the divider for the 16-bit weight and one multiply
// and round; a query clamped low or high skips the walk. One item is in work
// at a time; the next beat is accepted from the cycle after the result beat is
// taken. The stores need no clearing: only entries below the count are read.
module piecewise_linear_interpolator_unit
    import pli_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [63:0] s_tdata,   // coord_x[31:0], value_y[63:32]
    input  wire [1:0]  s_tuser,   // op
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [47:0] m_tdata,  // result_y[31:0], point_count[40:32], zero fill
    output logic [2:0] m_tuser    // status
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD0   = 11'b00000000010,
        S_RDL   = 11'b00000000100,
        S_CHK   = 11'b00000001000,
        S_WALK  = 11'b00000010000,
        S_WCHK  = 11'b00000100000,
        S_RDY1  = 11'b00001000000,
        S_RDY0  = 11'b00010000000,
        S_DIV   = 11'b00100000000,
        S_MUL   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [OP_W-1:0] op_reg;
    val_t x_reg, y_reg, x0_reg, x1_reg, y0_reg, res_reg;
    logic [STAT_W-1:0] stat_reg;
    logic signed [VALUE_WIDTH+1:0] dy_reg;
    logic [FRAC_W:0] t_reg;
    logic signed [VALUE_WIDTH+FRAC_W+3:0] prod_reg;

    logic ram_we;
    logic [ADDR_W-1:0] ram_addr;
    val_t xr, yr;
    logic [ADDR_W-1:0] last;
    assign last = ADDR_W'(count_reg - CNT_W'(1));

    pli_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_POINTS)) u_xram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(x_reg), .rdata(xr));
    pli_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_POINTS)) u_yram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(y_reg), .rdata(yr));

    // weight numerator/denominator magnitudes; x[i-1] arrives on xr while
    // the divider is started, so take it from there in that cycle
    logic signed [VALUE_WIDTH:0] dnum, dden;
    logic [VALUE_WIDTH:0] anum, aden;
    val_t x0_w;
    logic div_start, div_busy;
    logic [FRAC_W-1:0] quo;
    assign x0_w = (state_reg == S_RDY0) ? xr : x0_reg;
    assign dnum = $signed({x_reg[VALUE_WIDTH-1], x_reg})
                  - $signed({x0_w[VALUE_WIDTH-1], x0_w});
    assign dden = $signed({x1_reg[VALUE_WIDTH-1], x1_reg})
                  - $signed({x0_w[VALUE_WIDTH-1], x0_w});
    assign anum = dnum[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-dnum) : dnum;
    assign aden = dden[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-dden) : dden;

    pli_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(anum), .den(aden), .busy(div_busy), .quo(quo));

    logic in_acc;
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = idx_reg;
        div_start = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc) begin
                case (s_tuser)
                    OP_APPEND: state_next = S_RD0;
                    OP_QUERY:  state_next = S_RD0;
                    default:   state_next = S_OUT;
                endcase
            end
            S_RD0: begin
                if (op_reg == OP_APPEND) begin
                    ram_addr = ADDR_W'(count_reg);
                    ram_we   = count_reg < CNT_W'(MAX_POINTS);
                    state_next = S_OUT;
                end else if (count_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    ram_addr = '0;
                    state_next = S_RDL;
                end
            end
            S_RDL: begin
                ram_addr = last;
                state_next = S_CHK;
            end
            S_CHK: begin
                // xr holds x[last], x0_reg holds x[0]
                ram_addr = '0;
                if (x_reg < x0_reg || x_reg > xr) state_next = S_RDY1;
                else state_next = S_WALK;
            end
            S_WALK: begin
                ram_addr = idx_reg;
                state_next = S_WCHK;
            end
            S_WCHK: begin
                if (idx_reg < last && x_reg > xr) state_next = S_WALK;
                else state_next = S_RDY1;
            end
            S_RDY1: begin
                // clamped high reads the last point itself
                ram_addr = (idx_reg == '0 || stat_reg == ST_HIGH) ? idx_reg
                                                                  : idx_reg - ADDR_W'(1);
                state_next = S_RDY0;
            end
            S_RDY0: begin
                ram_addr = idx_reg;
                state_next = S_DIV;
                div_start = 1'b1;
            end
            S_DIV: if (!div_busy) state_next = S_MUL;
            S_MUL: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [VALUE_WIDTH+1:0] dy_w;
    assign dy_w = $signed({yr[VALUE_WIDTH-1], yr[VALUE_WIDTH-1], yr})
                - $signed({y0_reg[VALUE_WIDTH-1], y0_reg[VALUE_WIDTH-1], y0_reg});

    logic clamp, sign_ok;
    assign clamp   = (anum >= aden);
    assign sign_ok = dnum != '0 && (dnum[VALUE_WIDTH] == dden[VALUE_WIDTH]);

    logic signed [VALUE_WIDTH+FRAC_W+3:0] rnd;
    assign rnd = prod_reg + (VALUE_WIDTH+FRAC_W+4)'(1 << (FRAC_W-1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_tvalid  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (state_reg == S_OUT) m_tvalid <= 1'b1;
            if (in_acc && s_tuser == OP_CLEAR) count_reg <= '0;
            if (state_reg == S_RD0 && ram_we) count_reg <= count_reg + CNT_W'(1);
        end
        case (state_reg)
            S_IDLE: if (in_acc) begin
                op_reg   <= s_tuser;
                x_reg    <= s_tdata[31:0];
                y_reg    <= s_tdata[63:32];
                res_reg  <= '0;
                stat_reg <= ST_OK;
                idx_reg  <= '0;
            end
            S_RD0: begin
                if (op_reg == OP_APPEND && count_reg >= CNT_W'(MAX_POINTS))
                    stat_reg <= ST_FULL;
                if (op_reg == OP_QUERY && count_reg == '0) stat_reg <= ST_EMPTY;
            end
            S_RDL: x0_reg <= xr;
            S_CHK: begin
                if (x_reg < x0_reg) begin
                    stat_reg <= ST_LOW;
                    idx_reg  <= '0;
                end else if (x_reg > xr) begin
                    stat_reg <= ST_HIGH;
                    idx_reg  <= last;
                end
            end
            S_WCHK: if (idx_reg < last && x_reg > xr) idx_reg <= idx_reg + ADDR_W'(1);
                    else x1_reg <= xr;
            S_RDY1: ;
            S_RDY0: begin
                x0_reg <= xr;          // x[i-1]
                y0_reg <= yr;          // y[i-1]
            end
            S_DIV: begin
                if (!div_busy) dy_reg <= dy_w; // yr = y[i]
                if (!sign_ok) t_reg <= '0;
                else if (clamp) t_reg <= (FRAC_W+1)'(1 << FRAC_W);
                else t_reg <= {1'b0, quo};
            end
            S_MUL: begin
                prod_reg <= dy_reg * $signed({1'b0, t_reg});
            end
            S_OUT: begin
                if (op_reg == OP_QUERY && stat_reg != ST_EMPTY) begin
                    if (stat_reg == ST_LOW || stat_reg == ST_HIGH || idx_reg == '0)
                        res_reg <= y0_reg;
                    else if (x1_reg == x0_reg) begin
                        res_reg  <= '0;
                        stat_reg <= ST_EQUAL;
                    end else
                        res_reg <= y0_reg + VALUE_WIDTH'(rnd >>> FRAC_W);
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = {7'd0, CNT_W'(count_reg), res_reg};
    assign m_tuser = stat_reg;
endmodule
`default_nettype wire

// File: sim/piecewise_linear_interpolator_unit_test.sv
// Testbench for piecewise_linear_interpolator_unit: directed and random beats against
// an in-bench interpolation table predictor. Depends on pli_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

class interp_scoreboard;
    logic signed [31:0] tab_x[256];
    logic signed [31:0] tab_y[256];
    int unsigned        n_pts;
    logic [31:0]        want_y[$];
    logic [2:0]         want_st[$];
    logic [8:0]         want_cnt[$];
    int                 errors;
    int                 n_checked;
    int                 n_status[8];

    function new();
        n_pts = 0;
        errors = 0;
        n_checked = 0;
        foreach (n_status[k]) n_status[k] = 0;
    endfunction

    // floor(num*65536/den) clamped to 0..65536
    function automatic longint frac_weight(longint num, longint den);
        longint a, b;
        if (num == 0 || ((num < 0) != (den < 0))) return 0;
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        if (a >= b) return 65536;
        return (a * 65536) / b;
    endfunction

    function automatic longint round_scale(longint dy, longint t);
        longint q, r;
        q = dy / 65536;
        r = dy % 65536;
        if (r < 0) begin
            r += 65536;
            q -= 1;
        end
        return q * t + (r * t + 32768) / 65536;
    endfunction

    function void note_input(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
        longint res, x0, c, y0, t;
        logic [2:0] st;
        int unsigned last, i;
        res = 0;
        st = pli_pkg::ST_OK;
        if (op == pli_pkg::OP_CLEAR) begin
            n_pts = 0;
        end else if (op == pli_pkg::OP_APPEND) begin
            if (n_pts < 256) begin
                tab_x[n_pts] = x;
                tab_y[n_pts] = y;
                n_pts++;
            end else begin
                st = pli_pkg::ST_FULL;
            end
        end else if (op == pli_pkg::OP_QUERY) begin
            if (n_pts == 0) begin
                st = pli_pkg::ST_EMPTY;
            end else begin
                last = n_pts - 1;
                if (x < tab_x[0]) begin
                    res = tab_y[0];
                    st = pli_pkg::ST_LOW;
                end else if (x > tab_x[last]) begin
                    res = tab_y[last];
                    st = pli_pkg::ST_HIGH;
                end else begin
                    i = 0;
                    while (i < last && x > tab_x[i]) i++;
                    if (i == 0) begin
                        res = tab_y[0];
                    end else begin
                        x0 = tab_x[i-1];
                        c = longint'(tab_x[i]) - x0;
                        if (c == 0) begin
                            st = pli_pkg::ST_EQUAL;
                        end else begin
                            t = frac_weight(longint'(x) - x0, c);
                            y0 = tab_y[i-1];
                            res = y0 + round_scale(longint'(tab_y[i]) - y0, t);
                        end
                    end
                end
            end
        end
        want_y.push_back(res[31:0]);
        want_st.push_back(st);
        want_cnt.push_back(n_pts[8:0]);
    endfunction

    function void check_result(logic [31:0] ry, logic [2:0] st, logic [8:0] cnt);
        logic [31:0] ey;
        logic [2:0]  es;
        logic [8:0]  ec;
        if (want_y.size() == 0) begin
            $error("result beat with nothing expected: y=%h status=%0d count=%0d",
                   ry, st, cnt);
            errors++;
            return;
        end
        ey = want_y.pop_front();
        es = want_st.pop_front();
        ec = want_cnt.pop_front();
        n_checked++;
        n_status[es]++;
        if (ry !== ey) begin
            $error("result_y: expected %h, actual %h", ey, ry);
            errors++;
        end
        if (st !== es) begin
            $error("status: expected %0d, actual %0d", es, st);
            errors++;
        end
        if (cnt !== ec) begin
            $error("point_count: expected %0d, actual %0d", ec, cnt);
            errors++;
        end
    endfunction

    function int pending();
        return want_y.size();
    endfunction
endclass

module piecewise_linear_interpolator_unit_test;
    import pli_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire         s_tready;
    logic [63:0] s_tdata;   // coord_x[31:0], value_y[63:32]
    logic [1:0]  s_tuser;   // op
    wire         m_tvalid;
    logic        m_tready;
    wire [47:0]  m_tdata;   // result_y[31:0], point_count[40:32], zero fill
    wire [2:0]   m_tuser;   // status

    interp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int n_sent;

    piecewise_linear_interpolator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Generous bound for ~1500 beats, full-table queries and receiver stalls included.
    initial begin
        #(8 * 6_000_000);
        $display("** piecewise_linear_interpolator_unit: FAILED **");
        $finish;
    end

    // Receiver: randomly stall, score each accepted result beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[31:0], m_tuser, m_tdata[40:32]);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one beat: optional idle gap, then hold valid until accepted.
    // Valid stays high afterwards so the next beat can follow directly.
    task automatic send_beat(logic [1:0] op, logic [31:0] x, logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, x, y);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(65536 * 4) - 65536 * 2;
            default: return $urandom;
        endcase
    endfunction

    // Load an ascending table of n points, with occasional repeated x.
    task automatic load_table(int n, logic signed [31:0] base, int span);
        logic signed [31:0] x;
        x = base;
        for (int k = 0; k < n; k++) begin
            send_beat(OP_APPEND, x, rand_val());
            if ($urandom_range(9) != 0) x = x + $urandom_range(span, 1);
        end
    endtask

    task automatic random_phase(int items);
        logic signed [31:0] base, q;
        int n, span, done;
        done = 0;
        while (done < items) begin
            case ($urandom_range(9))
                0: begin
                    // noise: any op including no-op and unsorted appends
                    send_beat($urandom_range(3), rand_val(), rand_val());
                    done++;
                end
                default: begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(256, 200)
                                                  : $urandom_range(8, 1);
                    span = ($urandom_range(3) == 0) ? 1 << 20 : 1 << $urandom_range(18, 2);
                    base = $urandom_range(1 << 22) - (1 << 21);
                    send_beat(OP_CLEAR, $urandom, $urandom);
                    load_table(n, base, span);
                    done += n + 1;
                    for (int k = 0; k < $urandom_range(6, 2); k++) begin
                        q = base + $urandom_range(n * span + 4) - 2;
                        if ($urandom_range(7) == 0) q = $urandom;
                        send_beat(OP_QUERY, q, $urandom);
                        done++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        n_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty query, extremes, equal x, below/above, no-op, full.
        send_idle_pct = 28;
        recv_idle_pct = 88;
        send_beat(OP_QUERY, 32'h0, 32'h0);
        send_beat(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(OP_QUERY, 32'h8000_0000, 32'h0);
        send_beat(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(OP_QUERY, 32'h0, 32'hffff_ffff);
        send_beat(OP_QUERY, 32'h7fff_fffe, 32'h0);
        send_beat(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_APPEND, 32'h0001_0000, 32'h0000_0003);
        send_beat(OP_APPEND, 32'h0001_0000, 32'h0005_0000);
        send_beat(OP_APPEND, 32'h0003_0000, 32'hfffb_0000);
        send_beat(OP_QUERY, 32'h0000_8000, 32'h0);
        send_beat(OP_QUERY, 32'h0001_0000, 32'h0);
        send_beat(OP_QUERY, 32'h0002_0000, 32'h0);
        send_beat(OP_QUERY, 32'h0001_8000, 32'h0);
        send_beat(OP_QUERY, 32'h0004_0000, 32'h0);
        send_beat(2'd3, 32'h1234_5678, 32'h9abc_def0);
        send_beat(OP_APPEND, 32'h0002_0000, 32'h0001_0000);   // unsorted
        send_beat(OP_QUERY, 32'h0002_8000, 32'h0);
        drain();
        // Pause the sender until everything is back, then fill past capacity.
        send_beat(OP_CLEAR, 32'h0, 32'h0);
        load_table(256, 32'hff00_0000, 1 << 12);
        send_beat(OP_APPEND, 32'h7fff_0000, 32'h1);
        send_beat(OP_QUERY, 32'h7000_0000, 32'h0);
        send_beat(OP_QUERY, 32'h0000_0000, 32'h0);

        random_phase(480);
        drain();
        send_idle_pct = 88;
        recv_idle_pct = 28;
        random_phase(400);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);

        drain();
        repeat (600) @(posedge aclk);
        $display("Covered %0d beats, %0d results checked: clear/append/query/no-op,",
                 n_sent, sb.n_checked);
        $display("  low %0d, high %0d, equal-x %0d, empty %0d, full %0d.",
                 sb.n_status[ST_LOW], sb.n_status[ST_HIGH], sb.n_status[ST_EQUAL],
                 sb.n_status[ST_EMPTY], sb.n_status[ST_FULL]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** piecewise_linear_interpolator_unit: PASSED **");
        end else begin
            $display("** piecewise_linear_interpolator_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
